// ----- rtl/core/chorus_pkg.sv -----
// shared constants and control types for the chorus delay block
package chorus_pkg;

    // default sizing
    localparam int DELAY_DEPTH_DEF = 1024;
    localparam int BASE_DELAY_DEF  = 32;
    localparam int LFO_DIVIDER_DEF = 256;
    localparam int SAMPLE_BITS_DEF = 16;

    // lfo and mix arithmetic
    localparam int LFO_W    = 10;
    localparam int TICK_W   = 8;
    localparam int LFO_TOP  = 255;
    localparam int LFO_FOLD = 512;
    localparam int MIX_ONE  = 32768;

    // configuration port
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 2;
    localparam int CTRL_W    = 8;

    localparam logic [CFG_IDX_W-1:0] REG_LFO_INCREMENT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MOD_DEPTH     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WET_MIX       = 2'd2;

    // controller to datapath commands
    typedef struct packed {
        logic step_lfo;
        logic mul_tick;
        logic sum_lfo;
        logic mul_depth;
        logic sub_pos;
        logic add_len;
        logic rd_mem;
        logic mul_wet;
        logic wr_out;
    } t_cmd;

    // datapath to controller status
    typedef struct packed {
        logic idx_neg;
        logic out_busy;
    } t_status;

endpackage

// ----- rtl/core/chorus_ctrl.sv -----
// sequencing state machine for the chorus delay block
module chorus_ctrl
    import chorus_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  t_status i_status,
    output logic    o_in_stall,
    output t_cmd    o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_TICK,
        S_LFO,
        S_DEPTH,
        S_POS,
        S_WRAP,
        S_READ,
        S_MIX,
        S_OUT
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.step_lfo = 1'b1;
                    n_state        = S_TICK;
                end
            end
            S_TICK: begin
                o_cmd.mul_tick = 1'b1;
                n_state        = S_LFO;
            end
            S_LFO: begin
                o_cmd.sum_lfo = 1'b1;
                n_state       = S_DEPTH;
            end
            S_DEPTH: begin
                o_cmd.mul_depth = 1'b1;
                n_state         = S_POS;
            end
            S_POS: begin
                o_cmd.sub_pos = 1'b1;
                n_state       = S_WRAP;
            end
            S_WRAP: begin
                if (i_status.idx_neg) begin
                    o_cmd.add_len = 1'b1;
                end else begin
                    n_state = S_READ;
                end
            end
            S_READ: begin
                o_cmd.rd_mem = 1'b1;
                n_state      = S_MIX;
            end
            S_MIX: begin
                o_cmd.mul_wet = 1'b1;
                n_state       = S_OUT;
            end
            S_OUT: begin
                if (!i_status.out_busy) begin
                    o_cmd.wr_out = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);

endmodule

// ----- rtl/core/chorus_dp.sv -----
// lfo, delay line and mixer datapath of the chorus delay block
module chorus_dp
    import chorus_pkg::*;
#(
    parameter int DELAY_DEPTH = DELAY_DEPTH_DEF,
    parameter int BASE_DELAY  = BASE_DELAY_DEF,
    parameter int LFO_DIVIDER = LFO_DIVIDER_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  t_cmd                          i_cmd,
    output t_status                       o_status,
    input  logic signed [SAMPLE_BITS-1:0] i_sample_in,
    input  logic [CTRL_W-1:0]             i_lfo_increment,
    input  logic [CTRL_W-1:0]             i_mod_depth,
    input  logic [CFG_W-1:0]              i_wet_mix,
    input  logic                          i_out_stall,
    output logic                          o_out_valid,
    output logic signed [SAMPLE_BITS-1:0] o_sample_out
);

    localparam int AW = $clog2(DELAY_DEPTH);
    localparam int IW = ((AW > LFO_W) ? AW : LFO_W) + 2;
    localparam int PW = SAMPLE_BITS + 17;

    // lfo state
    logic signed [LFO_W-1:0] r_lfo, n_lfo;
    logic signed [LFO_W-1:0] r_prev, n_prev;
    logic                    r_fall, n_fall;
    logic [TICK_W-1:0]       r_tick, n_tick;

    // write side
    logic [AW-1:0] r_wp, n_wp;
    logic          r_wrapped;
    logic          r_out_valid;

    // working registers
    logic signed [SAMPLE_BITS-1:0] r_x;
    logic signed [19:0]            r_prod;
    logic [LFO_W-1:0]              r_acc;
    logic [LFO_W-1:0]              r_offset;
    logic signed [IW-1:0]          r_idx;
    logic signed [SAMPLE_BITS-1:0] r_rd;
    logic                          r_hit;
    logic signed [PW-1:0]          r_p1;
    logic signed [PW:0]            r_sum;
    logic signed [SAMPLE_BITS-1:0] r_sample_out;
    logic signed [SAMPLE_BITS-1:0] r_mem [DELAY_DEPTH];

    logic [TICK_W:0]               tick_inc;
    logic                          tick_wrap;
    logic signed [LFO_W:0]         lfo_up;
    logic signed [LFO_W:0]         lfo_dn;
    logic signed [LFO_W:0]         lfo_diff;
    logic signed [13:0]            lfo_bias;
    logic [17:0]                   depth_prod;
    logic [AW-1:0]                 rd_addr;
    logic [CFG_W-1:0]              mix;
    logic [CFG_W-1:0]              dry_coef;
    logic signed [SAMPLE_BITS-1:0] delayed;
    logic signed [PW-1:0]          wet_prod;

    // lfo step, taken when a beat is accepted
    assign tick_inc  = {1'b0, r_tick} + 1'b1;
    assign tick_wrap = (tick_inc >= (TICK_W + 1)'(LFO_DIVIDER));
    assign lfo_up    = {r_lfo[LFO_W-1], r_lfo} + $signed({3'b000, i_lfo_increment});
    assign lfo_dn    = {r_lfo[LFO_W-1], r_lfo} - $signed({3'b000, i_lfo_increment});

    always_comb begin
        n_lfo  = r_lfo;
        n_prev = r_prev;
        n_fall = r_fall;
        n_tick = tick_wrap ? '0 : tick_inc[TICK_W-1:0];
        if (tick_wrap) begin
            n_prev = r_lfo;
            if (!r_fall) begin
                if (lfo_up > LFO_TOP) begin
                    n_lfo  = LFO_W'(LFO_FOLD - lfo_up);
                    n_fall = 1'b1;
                end else begin
                    n_lfo = lfo_up[LFO_W-1:0];
                end
            end else begin
                if (lfo_dn < -LFO_TOP) begin
                    n_lfo  = LFO_W'(-LFO_FOLD - lfo_dn);
                    n_fall = 1'b0;
                end else begin
                    n_lfo = lfo_dn[LFO_W-1:0];
                end
            end
        end
    end

    assign n_wp = (r_wp == AW'(DELAY_DEPTH - 1)) ? '0 : r_wp + 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lfo       <= '0;
            r_prev      <= '0;
            r_fall      <= 1'b0;
            r_tick      <= '0;
            r_wp        <= '0;
            r_wrapped   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.step_lfo) begin
                r_lfo  <= n_lfo;
                r_prev <= n_prev;
                r_fall <= n_fall;
                r_tick <= n_tick;
            end
            if (i_cmd.wr_out) begin
                r_wp <= n_wp;
                if (r_wp == AW'(DELAY_DEPTH - 1)) begin
                    r_wrapped <= 1'b1;
                end
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // interpolation, offset and read address
    assign lfo_diff   = {r_lfo[LFO_W-1], r_lfo} - {r_prev[LFO_W-1], r_prev};
    assign lfo_bias   = 14'(r_prev) + 14'(r_prod >>> 8) + 14'sd255;
    assign depth_prod = r_acc * i_mod_depth;
    assign rd_addr    = r_idx[AW-1:0];

    // mix coefficients, saturated at fully wet
    assign mix      = (i_wet_mix > CFG_W'(MIX_ONE)) ? CFG_W'(MIX_ONE) : i_wet_mix;
    assign dry_coef = CFG_W'(MIX_ONE) - mix;
    assign delayed  = r_hit ? r_rd : '0;
    assign wet_prod = delayed * $signed({1'b0, mix});

    always_ff @(posedge i_clk) begin
        if (i_cmd.step_lfo) begin
            r_x <= i_sample_in;
        end
        if (i_cmd.mul_tick) begin
            r_prod <= $signed({1'b0, r_tick}) * lfo_diff;
        end
        if (i_cmd.sum_lfo) begin
            r_acc <= (lfo_bias < 0) ? '0 : lfo_bias[LFO_W-1:0];
        end
        if (i_cmd.mul_depth) begin
            r_offset <= depth_prod[17:8];
        end
        if (i_cmd.sub_pos) begin
            r_idx <= $signed({{(IW - AW){1'b0}}, r_wp}) - $signed(IW'(BASE_DELAY))
                     - $signed({{(IW - LFO_W){1'b0}}, r_offset});
        end else if (i_cmd.add_len) begin
            r_idx <= r_idx + $signed(IW'(DELAY_DEPTH));
        end
        if (i_cmd.rd_mem) begin
            r_hit <= r_wrapped || (rd_addr < r_wp);
            r_p1  <= r_x * $signed({1'b0, dry_coef});
        end
        if (i_cmd.mul_wet) begin
            r_sum <= (PW + 1)'(r_p1) + (PW + 1)'(wet_prod);
        end
        if (i_cmd.wr_out) begin
            r_sample_out <= r_sum[SAMPLE_BITS+14:15];
        end
    end

    // delay line: read before the new sample goes in
    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_mem) begin
            r_rd <= r_mem[rd_addr];
        end
        if (i_cmd.wr_out) begin
            r_mem[r_wp] <= r_x;
        end
    end

    assign o_status.idx_neg  = r_idx[IW-1];
    assign o_status.out_busy = r_out_valid && i_out_stall;
    assign o_out_valid       = r_out_valid;
    assign o_sample_out      = r_sample_out;

endmodule

// ----- rtl/core/chorus_delay_with_triangle_lfo.sv -----
// top level of the chorus delay with triangle lfo
// one signed sample in, one mixed sample out per beat. the block handles one
// beat at a time. DELAY_DEPTH is added back to the read position until it
// lies inside the delay line: 0 or 1 times with the default sizing, at most
// ceil((BASE_DELAY + 509) / DELAY_DEPTH) times in general. the controller
// steps through lfo step, tick multiply, interpolation, depth multiply, read
// position, wrap loop, delay line read with dry multiply, wet multiply and
// accumulate, and write back. a finished beat waits in the output register
// while the next sample is taken in; write back of the next beat stalls only
// if that register has not been drained. the delay line needs no clearing
// pass after reset: entries not yet written since reset read as zero, tracked
// from the write position and a wrap flag.
// configuration is written through a plain write port and should only change
// while the block is idle
module chorus_delay_with_triangle_lfo
    import chorus_pkg::*;
#(
    parameter int DELAY_DEPTH = DELAY_DEPTH_DEF,
    parameter int BASE_DELAY  = BASE_DELAY_DEF,
    parameter int LFO_DIVIDER = LFO_DIVIDER_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // configuration write port
    input  logic                          i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]          i_cfg_index,
    input  logic [CFG_W-1:0]              i_cfg_data,
    // input sample channel
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic signed [SAMPLE_BITS-1:0] i_sample_in,
    // output sample channel
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic signed [SAMPLE_BITS-1:0] o_sample_out
);

    // configuration registers
    logic [CTRL_W-1:0] r_lfo_increment;
    logic [CTRL_W-1:0] r_mod_depth;
    logic [CFG_W-1:0]  r_wet_mix;

    t_cmd    cmd;
    t_status status;

    // register decode, writes to unused indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lfo_increment <= '0;
            r_mod_depth     <= '0;
            r_wet_mix       <= '0;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                REG_LFO_INCREMENT: r_lfo_increment <= i_cfg_data[CTRL_W-1:0];
                REG_MOD_DEPTH:     r_mod_depth     <= i_cfg_data[CTRL_W-1:0];
                REG_WET_MIX:       r_wet_mix       <= i_cfg_data;
                default:           ;
            endcase
        end
    end

    // step sequencer
    chorus_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_status   (status),
        .o_in_stall (o_in_stall),
        .o_cmd      (cmd)
    );

    // lfo, delay line and mixer
    chorus_dp #(
        .DELAY_DEPTH (DELAY_DEPTH),
        .BASE_DELAY  (BASE_DELAY),
        .LFO_DIVIDER (LFO_DIVIDER),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_status        (status),
        .i_sample_in     (i_sample_in),
        .i_lfo_increment (r_lfo_increment),
        .i_mod_depth     (r_mod_depth),
        .i_wet_mix       (r_wet_mix),
        .i_out_stall     (i_out_stall),
        .o_out_valid     (o_out_valid),
        .o_sample_out    (o_sample_out)
    );

endmodule
